// File: src/aes128_cbc_decrypt_top_macros.svh
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt_top_macros
// assertion macros for the cbc decrypt block
// ----------------------------------------------------------------------------
`ifndef AES128_CBC_DECRYPT_TOP_MACROS_SVH
`define AES128_CBC_DECRYPT_TOP_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define AESCBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aescbc assertion failed");
// antecedent implies consequent in the next cycle
`define AESCBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aescbc assertion failed");
`else
`define AESCBC_ASSERT_SAME(label, ante, cons)
`define AESCBC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/aescbc_pkg.sv
// ----------------------------------------------------------------------------
// aescbc_pkg
// types, tables and round functions for the cbc decrypt block
// ----------------------------------------------------------------------------
package aescbc_pkg;

  localparam int RK_DEPTH  = 11;
  localparam int RK_WIDTH  = 128;
  localparam int RK_ADDR_W = $clog2(RK_DEPTH);
  localparam logic [RK_ADDR_W-1:0] RK_LAST = RK_ADDR_W'(RK_DEPTH - 1);

  localparam logic [1:0] REG_KEY_HI = 2'd0;
  localparam logic [1:0] REG_KEY_LO = 2'd1;
  localparam logic [1:0] REG_IV_HI  = 2'd2;
  localparam logic [1:0] REG_IV_LO  = 2'd3;

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_ADD,
    ST_ROUND
  } state_t;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] INV_SBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    sbox = SBOX_TBL[(255 - int'(b)) * 8 +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] b);
    inv_sbox = INV_SBOX_TBL[(255 - int'(b)) * 8 +: 8];
  endfunction

  function automatic logic [7:0] rcon(input logic [RK_ADDR_W-1:0] i);
    unique case (i)
      4'd0:    rcon = 8'h01;
      4'd1:    rcon = 8'h02;
      4'd2:    rcon = 8'h04;
      4'd3:    rcon = 8'h08;
      4'd4:    rcon = 8'h10;
      4'd5:    rcon = 8'h20;
      4'd6:    rcon = 8'h40;
      4'd7:    rcon = 8'h80;
      4'd8:    rcon = 8'h1b;
      4'd9:    rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 of a block sits in bits 127:120
  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    next_round_key = {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] o;
    int src;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = r + 4 * ((c + 4 - r) % 4);
        o[127 - 8 * (r + 4 * c) -: 8] = inv_sbox(s[127 - 8 * src -: 8]);
      end
    end
    inv_shift_sub = o;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]   = s[127 - 8 * (4 * c + r) -: 8];
        x2     = xtime(a[r]);
        x4     = xtime(x2);
        x8     = xtime(x4);
        m9[r]  = x8 ^ a[r];
        m11[r] = x8 ^ x2 ^ a[r];
        m13[r] = x8 ^ x4 ^ a[r];
        m14[r] = x8 ^ x4 ^ x2;
      end
      o[127 - 8 * (4 * c)     -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      o[127 - 8 * (4 * c + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      o[127 - 8 * (4 * c + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      o[127 - 8 * (4 * c + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    inv_mix = o;
  endfunction

endpackage

// File: src/aes128_cbc_decrypt_top.sv
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt_top
// aes-128 cbc decryption, round keys held in a ram; unless the output stalls, one round per cycle
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 payload
//  in_      in   in_tvalid / in_tready     tdata = ct_high, ct_low; tlast = last_block
//  out_     out  out_tvalid / out_tready   tdata = pt_high, pt_low; tlast = last_out
//  cfg_     in   cfg_wr_en                 cfg_index, cfg_data (64 bit)
//
//  a block passes from accept to result through the initial key add and ten
//  inverse rounds, each using one round key read ahead from the key ram. a
//  new block is accepted only in the idle state, after the last round of the one before.
//  after reset and after each key write, key expansion writes all eleven round keys
//  into the ram; no request is accepted then. the output register lets the next block
//  be accepted while a result waits; the last round stalls if it still waits.
// ----------------------------------------------------------------------------
module aes128_cbc_decrypt_top
  import aescbc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] ct_high, [127:64] ct_low
  input  logic         in_tlast,   // last_block
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] pt_high, [127:64] pt_low
  output logic         out_tlast,  // last_out
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  `include "aes128_cbc_decrypt_top_macros.svh"

  state_t state_r, state_nxt;

  logic [63:0]          key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [127:0]         chain_r, chain_nxt;
  logic [127:0]         exp_key_r;
  logic [RK_ADDR_W-1:0] exp_cnt_r;
  logic [RK_ADDR_W-1:0] rnd_r;
  logic [127:0]         blk_r, ct_r;
  logic                 last_r;
  logic                 out_valid_r;
  logic [127:0]         out_data_r;
  logic                 out_last_r;

  logic                 in_fire, out_free, final_fire, key_wr, exp_done;
  logic                 ram_we, ram_re;
  logic [RK_ADDR_W-1:0] ram_raddr;
  logic [127:0]         rk, round_val, pt;

  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign key_wr     = cfg_wr_en && (cfg_index == REG_KEY_HI || cfg_index == REG_KEY_LO);
  assign exp_done   = (exp_cnt_r == RK_LAST);
  assign final_fire = (state_r == ST_ROUND) && (rnd_r == '0) && out_free;
  assign ram_we     = (state_r == ST_EXPAND);

  aescbc_ram #(
    .WIDTH (RK_WIDTH),
    .DEPTH (RK_DEPTH)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (exp_cnt_r),
    .wdata (exp_key_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rk)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EXPAND: if (exp_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_fire) state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_ROUND;
      ST_ROUND:  if (final_fire) state_nxt = ST_IDLE;
      default:   state_nxt = ST_EXPAND;
    endcase
    if (key_wr) begin
      state_nxt = ST_EXPAND;
    end
  end

  // outputs and ram read control
  always_comb begin
    in_tready = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rnd_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_re    = in_fire;
        ram_raddr = RK_LAST;
      end
      ST_ADD: begin
        ram_re = 1'b1;
      end
      ST_ROUND: begin
        // hold the read data while the last round stalls
        ram_re    = (rnd_r != '0);
        ram_raddr = rnd_r - 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  assign round_val = inv_shift_sub(blk_r) ^ rk;
  assign pt        = round_val ^ chain_r;

  always_comb begin
    chain_nxt = chain_r;
    if (final_fire) begin
      chain_nxt = ct_r;
    end
    if (cfg_wr_en && cfg_index == REG_IV_HI) begin
      chain_nxt = {cfg_data, iv_lo_r};
    end else if (cfg_wr_en && cfg_index == REG_IV_LO) begin
      chain_nxt = {iv_hi_r, cfg_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXPAND;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
      iv_hi_r     <= '0;
      iv_lo_r     <= '0;
      chain_r     <= '0;
      exp_key_r   <= '0;
      exp_cnt_r   <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      if (cfg_wr_en && cfg_index == REG_KEY_HI) key_hi_r <= cfg_data;
      if (cfg_wr_en && cfg_index == REG_KEY_LO) key_lo_r <= cfg_data;
      if (cfg_wr_en && cfg_index == REG_IV_HI)  iv_hi_r  <= cfg_data;
      if (cfg_wr_en && cfg_index == REG_IV_LO)  iv_lo_r  <= cfg_data;

      if (key_wr) begin
        exp_cnt_r <= '0;
        exp_key_r <= (cfg_index == REG_KEY_HI) ? {cfg_data, key_lo_r} : {key_hi_r, cfg_data};
      end else if (state_r == ST_EXPAND) begin
        exp_cnt_r <= exp_cnt_r + 1'b1;
        exp_key_r <= next_round_key(exp_key_r, rcon(exp_cnt_r));
      end

      if (in_fire) begin
        rnd_r <= RK_LAST - 1'b1;
      end else if (state_r == ST_ROUND && rnd_r != '0) begin
        rnd_r <= rnd_r - 1'b1;
      end

      if (final_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      blk_r  <= {in_tdata[63:0], in_tdata[127:64]};
      ct_r   <= {in_tdata[63:0], in_tdata[127:64]};
      last_r <= in_tlast;
    end else if (state_r == ST_ADD) begin
      blk_r <= blk_r ^ rk;
    end else if (state_r == ST_ROUND && rnd_r != '0) begin
      blk_r <= inv_mix(round_val);
    end
    if (final_fire) begin
      out_data_r <= {pt[63:0], pt[127:64]};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `AESCBC_ASSERT_SAME(a_ram_wr_expand, ram_we, !in_tready)
  `AESCBC_ASSERT_NEXT(a_key_wr_expand, key_wr, state_r == ST_EXPAND)
  `AESCBC_ASSERT_NEXT(a_stall_holds, state_r == ST_ROUND && rnd_r == '0 && !out_free,
                      state_r == ST_ROUND && $stable(rk))
  `AESCBC_ASSERT_NEXT(a_final_sets_out, final_fire, out_valid_r)

endmodule

// File: src/aescbc_ram.sv
// ----------------------------------------------------------------------------
// aescbc_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module aescbc_ram
  import aescbc_pkg::*;
#(
  parameter int WIDTH = RK_WIDTH,
  parameter int DEPTH = RK_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: test/tb_aes128_cbc_decrypt_top.sv
// ----------------------------------------------------------------------------
// tb_aes128_cbc_decrypt_top
// drives ciphertext blocks through the cbc decrypt block with random bursts
// and output stalls, and checks each plaintext against a behavioral decryptor
// kept in step with the key and iv writes
// ----------------------------------------------------------------------------
module tb_aes128_cbc_decrypt_top;
  import aescbc_pkg::*;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } block_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tlast;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = REG_KEY_HI;
  logic [63:0]  cfg_data = '0;

  aes128_cbc_decrypt_top u_top (.*);

  always #5 clk = ~clk;

  // decryptor state
  logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic [127:0] sched [11];
  logic [127:0] chain_q;
  logic [127:0] pt_exp;

  block_t pending_ct [$];
  block_t expected_pt [$];
  int     errors = 0;
  bit     feeding = 1'b0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     stall_phase = 0;

  function automatic logic [7:0] fwd_sub(input logic [7:0] b);
    logic [7:0] inv, p, q;
    // search the inverse table for the forward substitution
    for (int v = 0; v < 256; v++) begin
      p = 8'(v);
      inv = INV_SBOX_TBL[(255 - v) * 8 +: 8];
      if (inv == b) q = p;
    end
    return q;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input int m);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] inv_sub(input logic [7:0] b);
    return INV_SBOX_TBL[(255 - int'(b)) * 8 +: 8];
  endfunction

  task automatic build_schedule();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    {w[0], w[1], w[2], w[3]} = {key_hi_q, key_lo_q};
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fwd_sub(t[23:16]) ^ rc, fwd_sub(t[15:8]), fwd_sub(t[7:0]),
             fwd_sub(t[31:24])};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++)
      sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [127:0] decrypt_block(input logic [127:0] ct);
    logic [7:0] s [16];
    logic [7:0] o [16];
    logic [127:0] v;
    v = ct ^ sched[10];
    for (int r = 9; r >= 0; r--) begin
      for (int i = 0; i < 16; i++) s[i] = v[127 - 8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++)
          o[j + 4*c] = inv_sub(s[j + 4*((c + 4 - j) % 4)]);
      for (int i = 0; i < 16; i++) v[127 - 8*i -: 8] = o[i];
      v ^= sched[r];
      if (r > 0) begin
        for (int i = 0; i < 16; i++) s[i] = v[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++) begin
          o[4*c]   = gf_mul(s[4*c], 14) ^ gf_mul(s[4*c+1], 11)
                   ^ gf_mul(s[4*c+2], 13) ^ gf_mul(s[4*c+3], 9);
          o[4*c+1] = gf_mul(s[4*c], 9) ^ gf_mul(s[4*c+1], 14)
                   ^ gf_mul(s[4*c+2], 11) ^ gf_mul(s[4*c+3], 13);
          o[4*c+2] = gf_mul(s[4*c], 13) ^ gf_mul(s[4*c+1], 9)
                   ^ gf_mul(s[4*c+2], 14) ^ gf_mul(s[4*c+3], 11);
          o[4*c+3] = gf_mul(s[4*c], 11) ^ gf_mul(s[4*c+1], 13)
                   ^ gf_mul(s[4*c+2], 9) ^ gf_mul(s[4*c+3], 14);
        end
        for (int i = 0; i < 16; i++) v[127 - 8*i -: 8] = o[i];
      end
    end
    return v;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_KEY_HI: key_hi_q = val;
      REG_KEY_LO: key_lo_q = val;
      REG_IV_HI:  iv_hi_q = val;
      default:    iv_lo_q = val;
    endcase
    if (idx == REG_KEY_HI || idx == REG_KEY_LO) build_schedule();
    else chain_q = {iv_hi_q, iv_lo_q};
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  task automatic add_ct(input logic [63:0] hi, input logic [63:0] lo, input logic last);
    pending_ct.push_back('{hi, lo, last});
  endtask

  task automatic run_phase();
    feeding = 1'b1;
    wait (pending_ct.size() == 0 && !in_tvalid);
    wait (expected_pt.size() == 0);
    feeding = 1'b0;
    repeat (20) @(posedge clk);
  endtask

  // driver, also queues the expected plaintext of each accepted block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pt_exp = decrypt_block({in_tdata[63:0], in_tdata[127:64]}) ^ chain_q;
        expected_pt.push_back('{pt_exp[127:64], pt_exp[63:0], in_tlast});
        chain_q = {in_tdata[63:0], in_tdata[127:64]};
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (feeding && pending_ct.size() > 0) begin
          block_t b;
          b = pending_ct.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {b.lo, b.hi};
          in_tlast  <= b.last;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else in_tvalid <= 1'b0;
      end
    end
  end

  // monitor, also drives the output stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_pt.size() == 0) begin
          $display("%0t unexpected plaintext %h last %b", $time, out_tdata, out_tlast);
          errors++;
        end else begin
          block_t e;
          e = expected_pt.pop_front();
          if (out_tdata[63:0] !== e.hi)
            $display("%0t pt_high expected %h actual %h", $time, e.hi, out_tdata[63:0]);
          if (out_tdata[127:64] !== e.lo)
            $display("%0t pt_low expected %h actual %h", $time, e.lo, out_tdata[127:64]);
          if (out_tlast !== e.last)
            $display("%0t last_out expected %b actual %b", $time, e.last, out_tlast);
          if (out_tdata !== {e.lo, e.hi} || out_tlast !== e.last) errors++;
        end
      end
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 20) out_tready <= 1'b1;
      else if (stall_phase < 40) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 1) == 0);
    end
  end

  initial begin
    key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
    build_schedule();
    chain_q = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (15) @(posedge clk);
    // reset key and iv
    add_ct('0, '0, 1'b0);
    add_ct('1, '1, 1'b1);
    run_phase();
    // standard test vector key with a known iv
    write_reg(REG_KEY_HI, 64'h2b7e151628aed2a6);
    write_reg(REG_KEY_LO, 64'habf7158809cf4f3c);
    write_reg(REG_IV_HI, 64'h0001020304050607);
    write_reg(REG_IV_LO, 64'h08090a0b0c0d0e0f);
    repeat (15) @(posedge clk);
    add_ct(64'h7649abac8119b246, 64'hcee98e9b12e9197d, 1'b0);
    add_ct(64'h5086cb9b507219ee, 64'h95db113a917678b2, 1'b1);
    for (int i = 0; i < 64; i++)
      add_ct(64'h1 << i, ~(64'h1 << i), i[0]);
    run_phase();
    write_reg(REG_KEY_HI, '1);
    write_reg(REG_KEY_LO, '1);
    write_reg(REG_IV_HI, '1);
    write_reg(REG_IV_LO, '1);
    repeat (15) @(posedge clk);
    for (int i = 0; i < 8; i++) add_ct(edge64(), edge64(), $urandom_range(0, 1));
    run_phase();
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_KEY_HI, edge64());
      write_reg(REG_KEY_LO, edge64());
      if ($urandom_range(0, 1)) write_reg(REG_IV_HI, edge64());
      write_reg(REG_IV_LO, edge64());
      repeat (15) @(posedge clk);
      for (int i = 0; i < 100; i++)
        add_ct(rand64(), ($urandom_range(0, 9) == 0) ? edge64() : rand64(),
               $urandom_range(0, 3) == 0);
      run_phase();
    end
    repeat (30) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
